[rtl/core/multichannel_biquad_iir_filter_macros.svh]
// Assertion helpers for the checker file of this block.
`ifndef MULTICHANNEL_BIQUAD_IIR_FILTER_MACROS_SVH
`define MULTICHANNEL_BIQUAD_IIR_FILTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MBQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mbq_pkg.sv]
`default_nettype none
package mbq_pkg;

	localparam int CHANNELS       = 8;
	localparam int COEF_FRAC_BITS = 16;

	localparam int CODE_W   = 8;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 24;
	localparam int IDX_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Product of a coefficient and a zero-extended sample, and a sum of five of them.
	localparam int PROD_W = COEF_W + SAMPLE_W + 1;
	localparam int ACC_W  = PROD_W + 3;
	localparam int SH_W   = ACC_W - COEF_FRAC_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A0 = 3'd0,
		REG_A1 = 3'd1,
		REG_A2 = 3'd2,
		REG_B1 = 3'd3,
		REG_B2 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] a0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
	} coef_set_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] x1;
		logic [SAMPLE_W-1:0] x2;
		logic [SAMPLE_W-1:0] y1;
		logic [SAMPLE_W-1:0] y2;
	} hist_t;

	typedef struct packed {
		logic                en;
		logic [CH_W-1:0]     idx;
		logic [SAMPLE_W-1:0] x;
		logic [SAMPLE_W-1:0] y;
	} hist_wr_t;

	typedef struct packed {
		logic            ok;
		logic [CH_W-1:0] idx;
	} chan_sel_t;

	// A code selects a channel only if exactly one bit is set and that channel exists.
	function automatic chan_sel_t decode_code(input logic [CODE_W-1:0] code);
		chan_sel_t        r;
		logic [IDX_W-1:0] k;
		k = '0;
		for (int i = 0; i < CODE_W; i++) begin
			if (code[i]) begin
				k = k | IDX_W'(i);
			end
		end
		r.ok  = (code != '0) && ((code & (code - 1'b1)) == '0)
			&& ({1'b0, k} < (IDX_W + 1)'(CHANNELS));
		r.idx = CH_W'(k);
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/multichannel_biquad_iir_filter.sv]
// Eight-channel direct-form-I biquad filter with one set of shared coefficients.
// Input stream: s_axis_tdata carries the unsigned 16-bit sample, s_axis_tuser the
// one-hot channel code. A code that is zero, has several bits set or names a
// missing channel is taken and dropped: no result, no history change.
// Output stream: m_axis_tdata carries the filtered 16-bit value, m_axis_tuser the
// binary channel index. Results leave in the order their samples arrived.
// Coefficients are written through the cfg port (index 0..4 = a0, a1, a2, b1, b2,
// signed, 16 fraction bits); the user must write them only while no sample is in
// flight, which the block does not enforce; cfg_ready is high. One sample a cycle
// is sustained without an output stall, also on the same channel, since the whole
// filter step is combinational between the input register and the output register
// and writes the channel history at the same edge as the result.
// When the receiver stalls, the held result stays put, one further valid request
// is taken into the input register, and then s_axis_tready drops until it moves;
// requests with a bad code keep being taken and dropped until then.
// Reset clears both streams, the channel histories, and loads a0 = 1.0, others 0.
`default_nettype none
module multichannel_biquad_iir_filter
	import mbq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [SAMPLE_W-1:0]  s_axis_tdata,  // [15:0] sample
	input  wire logic [CODE_W-1:0]    s_axis_tuser,  // [7:0] channel_code
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [SAMPLE_W-1:0]       m_axis_tdata,  // [15:0] filtered
	output logic [IDX_W-1:0]          m_axis_tuser,  // [2:0] channel_index
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COEF_W-1:0]    cfg_data
);

	coef_set_t           coef_q;
	logic                valid_s1, valid_s2;
	logic [CH_W-1:0]     idx_s1, idx_s2;
	logic [SAMPLE_W-1:0] sample_s1, filt_s2;

	chan_sel_t           sel;
	logic                adv, s_acc;
	hist_t               hist;
	hist_wr_t            hist_wr;
	logic [SAMPLE_W-1:0] y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a0 <= COEF_W'(32'sd1 <<< COEF_FRAC_BITS);
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_A0: coef_q.a0 <= cfg_data;
				REG_A1: coef_q.a1 <= cfg_data;
				REG_A2: coef_q.a2 <= cfg_data;
				REG_B1: coef_q.b1 <= cfg_data;
				REG_B2: coef_q.b2 <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv           = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign sel           = decode_code(s_axis_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_acc) begin
				valid_s1 <= sel.ok;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			idx_s1    <= sel.idx;
			sample_s1 <= s_axis_tdata;
		end
		if (hist_wr.en) begin
			idx_s2  <= idx_s1;
			filt_s2 <= y;
		end
	end

	assign hist_wr.en  = valid_s1 && adv;
	assign hist_wr.idx = idx_s1;
	assign hist_wr.x   = sample_s1;
	assign hist_wr.y   = y;

	mbq_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx_s1),
		.wr     (hist_wr),
		.rd     (hist)
	);

	mbq_mac u_mac (
		.coef (coef_q),
		.hist (hist),
		.x    (sample_s1),
		.y    (y)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = filt_s2;
	assign m_axis_tuser  = IDX_W'(idx_s2);

endmodule
`default_nettype wire

[rtl/core/mbq_hist.sv]
`default_nettype none
module mbq_hist
	import mbq_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [CH_W-1:0] rd_idx,
	input  wire hist_wr_t        wr,
	output hist_t                rd
);

	hist_t hist_q [CHANNELS];

	assign rd = hist_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				hist_q[c] <= '0;
			end
		end else if (wr.en) begin
			hist_q[wr.idx].x2 <= hist_q[wr.idx].x1;
			hist_q[wr.idx].x1 <= wr.x;
			hist_q[wr.idx].y2 <= hist_q[wr.idx].y1;
			hist_q[wr.idx].y1 <= wr.y;
		end
	end

endmodule
`default_nettype wire

[rtl/core/mbq_mac.sv]
`default_nettype none
module mbq_mac
	import mbq_pkg::*;
(
	input  wire coef_set_t           coef,
	input  wire hist_t               hist,
	input  wire logic [SAMPLE_W-1:0] x,
	output logic [SAMPLE_W-1:0]      y
);

	logic signed [SAMPLE_W:0]   xs, x1s, x2s, y1s, y2s;
	logic signed [PROD_W-1:0]   p0, p1, p2, p3, p4;
	logic signed [ACC_W-1:0]    acc;
	logic        [SH_W-1:0]     whole;

	assign xs  = $signed({1'b0, x});
	assign x1s = $signed({1'b0, hist.x1});
	assign x2s = $signed({1'b0, hist.x2});
	assign y1s = $signed({1'b0, hist.y1});
	assign y2s = $signed({1'b0, hist.y2});

	assign p0 = coef.a0 * xs;
	assign p1 = coef.a1 * x1s;
	assign p2 = coef.a2 * x2s;
	assign p3 = coef.b1 * y1s;
	assign p4 = coef.b2 * y2s;

	assign acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + ACC_W'(p3) + ACC_W'(p4);

	// For a positive sum, dropping the fraction bits truncates towards zero.
	assign whole = acc[ACC_W-1:COEF_FRAC_BITS];

	always_comb begin
		if (acc[ACC_W-1] || (acc == '0)) begin
			y = '0;
		end else if (|whole[SH_W-1:SAMPLE_W]) begin
			y = '1;
		end else begin
			y = whole[SAMPLE_W-1:0];
		end
	end

endmodule
`default_nettype wire

[rtl/core/mbq_checker.sv]
`default_nettype none
`include "multichannel_biquad_iir_filter_macros.svh"
module mbq_checker
	import mbq_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_axis_tready,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [SAMPLE_W-1:0] m_axis_tdata,
	input wire logic [IDX_W-1:0]    m_axis_tuser
);

	// A stalled result must hold its value and stay offered.
	`MBQ_ASSERT_NEXT(a_out_hold, clk, arst_n, (m_axis_tvalid && !m_axis_tready), (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

	// Only channels that exist may be reported.
	`MBQ_ASSERT_IMPL(a_idx_range, clk, arst_n, m_axis_tvalid, ({1'b0, m_axis_tuser} < (IDX_W + 1)'(CHANNELS)), "channel index out of range")

	// The input side may only push back while the output side is stalled.
	`MBQ_ASSERT_IMPL(a_back_pressure, clk, arst_n, !s_axis_tready, (m_axis_tvalid && !m_axis_tready), "input stalled without output stall")

endmodule

bind multichannel_biquad_iir_filter mbq_checker u_mbq_checker (.*);
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
module tb_top;
	import mbq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int OUT_MAX = (1 << SAMPLE_W) - 1;
	localparam int CFG_INDEX_UNUSED = int'(REG_B2) + 1;
	localparam int CFG_INDEX_LAST = (1 << CFG_IDX_W) - 1;
	localparam int ITEMS_PER_SET = 109;
	localparam logic [CODE_W-1:0] CODE_NONE = '0;
	localparam logic [CODE_W-1:0] CODE_ALL = '1;
	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS);
	localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	typedef struct {
		logic [IDX_W-1:0]    channel;
		logic [SAMPLE_W-1:0] value;
	} filter_out_t;

	class filter_scoreboard;
		logic signed [COEF_W-1:0] a0, a1, a2, b1, b2;
		logic [SAMPLE_W-1:0] x1 [CHANNELS];
		logic [SAMPLE_W-1:0] x2 [CHANNELS];
		logic [SAMPLE_W-1:0] y1 [CHANNELS];
		logic [SAMPLE_W-1:0] y2 [CHANNELS];
		filter_out_t expected_outputs [$];
		int fail_count;

		function new();
			a0 = COEF_ONE;
			a1 = '0;
			a2 = '0;
			b1 = '0;
			b2 = '0;
			foreach (x1[k]) begin
				x1[k] = '0;
				x2[k] = '0;
				y1[k] = '0;
				y2[k] = '0;
			end
			fail_count = 0;
		endfunction

		function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
			case (idx)
				REG_A0: a0 = val;
				REG_A1: a1 = val;
				REG_A2: a2 = val;
				REG_B1: b1 = val;
				REG_B2: b2 = val;
				default: ;
			endcase
		endfunction

		// Runs one filter step on the selected channel and queues its output.
		function void note_sample(logic [CODE_W-1:0] code, logic [SAMPLE_W-1:0] x);
			int k;
			longint acc;
			logic [SAMPLE_W-1:0] y;
			filter_out_t e;
			if ($countones(code) != 1)
				return;
			k = 0;
			while (!code[k])
				k++;
			if (k >= CHANNELS)
				return;
			acc = longint'(a0) * longint'(x) + longint'(a1) * longint'(x1[k])
				+ longint'(a2) * longint'(x2[k]) + longint'(b1) * longint'(y1[k])
				+ longint'(b2) * longint'(y2[k]);
			if (acc <= 0)
				y = '0;
			else if ((acc >>> COEF_FRAC_BITS) > OUT_MAX)
				y = '1;
			else
				y = SAMPLE_W'(acc >>> COEF_FRAC_BITS);
			x2[k] = x1[k];
			x1[k] = x;
			y2[k] = y1[k];
			y1[k] = y;
			e.channel = IDX_W'(k);
			e.value = y;
			expected_outputs.push_back(e);
		endfunction

		function void check_output(logic [IDX_W-1:0] ch, logic [SAMPLE_W-1:0] y);
			filter_out_t e;
			if (expected_outputs.size() == 0) begin
				$display("%0t: unexpected output: channel %0d value %0d", $time, ch, y);
				fail_count++;
				return;
			end
			e = expected_outputs.pop_front();
			if (ch !== e.channel) begin
				$display("%0t: channel mismatch: expected %0d, actual %0d",
					$time, e.channel, ch);
				fail_count++;
			end
			if (y !== e.value) begin
				$display("%0t: filtered mismatch on channel %0d: expected %0d, actual %0d",
					$time, e.channel, e.value, y);
				fail_count++;
			end
		endfunction

		function int pending();
			return expected_outputs.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [SAMPLE_W-1:0]  s_axis_tdata;   // [15:0] sample
	logic [CODE_W-1:0]    s_axis_tuser;   // [7:0] channel_code
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [SAMPLE_W-1:0]  m_axis_tdata;   // [15:0] filtered
	logic [IDX_W-1:0]     m_axis_tuser;   // [2:0] channel_index
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	filter_scoreboard sb;
	int src_idle_pct;
	int sink_idle_pct;
	int cycle_count;

	multichannel_biquad_iir_filter u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_output(m_axis_tuser, m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_sample(s_axis_tuser, s_axis_tdata);
			if (cfg_valid && cfg_ready)
				sb.set_coef(cfg_index, cfg_data);
		end
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_sample(input logic [CODE_W-1:0] code, input logic [SAMPLE_W-1:0] x);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= code;
		s_axis_tdata <= x;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Writes all five coefficients and one unused index, which must be ignored.
	task automatic load_coefs(input coef_set_t c);
		put_reg(REG_A0, c.a0);
		put_reg(REG_A1, c.a1);
		put_reg(REG_A2, c.a2);
		put_reg(REG_B1, c.b1);
		put_reg(REG_B2, c.b2);
		put_reg(CFG_IDX_W'($urandom_range(CFG_INDEX_LAST, CFG_INDEX_UNUSED)),
			COEF_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Stops the input stream and lets every outstanding request drain.
	task automatic settle_filter();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly gains from -2.0 to 2.0; sometimes any value.
	function automatic logic [COEF_W-1:0] rand_coef();
		if ($urandom_range(3) == 0)
			return COEF_W'($urandom);
		return COEF_W'(int'($urandom_range(1 << 18)) - (1 << 17));
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] rand_code();
		if ($urandom_range(99) < 85)
			return CODE_W'(1) << $urandom_range(CODE_W - 1);
		return CODE_W'($urandom);
	endfunction

	initial begin
		coef_set_t c;
		sb = new();
		cycle_count = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_idle_pct = 37;
		sink_idle_pct = 80;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset gains pass samples straight through, one per channel.
		for (int k = 0; k < CHANNELS; k++)
			send_sample(CODE_W'(1) << k, (k == 0) ? '1 : (k == CHANNELS - 1) ? '0 :
				SAMPLE_W'($urandom));
		send_sample(CODE_NONE, SAMPLE_W'($urandom));
		send_sample(CODE_W'(3), SAMPLE_W'($urandom));
		send_sample(CODE_ALL, SAMPLE_W'($urandom));
		send_sample(CODE_W'(1) | (CODE_W'(1) << (CODE_W - 1)), SAMPLE_W'($urandom));

		// Largest gain: a small sample scales up, a full-scale one saturates.
		settle_filter();
		c = '{a0: COEF_MAX, a1: '0, a2: '0, b1: '0, b2: '0};
		load_coefs(c);
		send_sample(CODE_W'(1) << 3, SAMPLE_W'(1));
		send_sample(CODE_W'(1) << 3, '1);

		// Most negative gain drives the sum below zero.
		settle_filter();
		c = '{a0: COEF_MIN, a1: '0, a2: '0, b1: '0, b2: '0};
		load_coefs(c);
		send_sample(CODE_W'(1) << 4, '1);

		// Full section with feedback on a single channel.
		settle_filter();
		c = '{a0: COEF_ONE >> 1, a1: COEF_ONE >> 2, a2: COEF_ONE >> 2,
			b1: COEF_ONE >> 1, b2: -(COEF_ONE >> 2)};
		load_coefs(c);
		send_sample(CODE_W'(1) << 2, '1);
		send_sample(CODE_W'(1) << 2, '0);
		send_sample(CODE_W'(1) << 2, SAMPLE_W'(40000));
		send_sample(CODE_W'(1) << 2, '1);
		send_sample(CODE_W'(1) << 2, SAMPLE_W'(12345));

		for (int mode = 0; mode < 3; mode++) begin
			src_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 80 : 0;
			sink_idle_pct = (mode == 0) ? 80 : (mode == 1) ? 37 : 0;
			for (int set = 0; set < 5; set++) begin
				settle_filter();
				c = '{a0: rand_coef(), a1: rand_coef(), a2: rand_coef(),
					b1: rand_coef(), b2: rand_coef()};
				load_coefs(c);
				repeat (ITEMS_PER_SET)
					send_sample(rand_code(), rand_sample());
			end
		end

		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
